>>> design/fsws_pkg.sv
package fsws_pkg;

   // Fixed field widths of the ports.
   localparam int ByteW    = 8;
   localparam int PatternW = 64;
   localparam int HdrLenW  = 7;

   // Configuration port.
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = PatternW;

   localparam logic [CsrIndexW-1:0] CsrHeaderPattern = 1'd0;
   localparam logic [CsrIndexW-1:0] CsrHeaderLength  = 1'd1;

   // Register reset values.
   localparam logic [PatternW-1:0] PatternReset = '0;
   localparam logic [HdrLenW-1:0]  LengthReset  = 7'd8;

   // Default and upper bound of the window depth.
   localparam int MaxHeaderDefault = 64;

endpackage

>>> design/fsws_corr.sv
// Sync word correlator: compares the newest len flags of the delay line
// against the pattern, true or inverted.
module fsws_corr #(
   parameter int MAX_HEADER = fsws_pkg::MaxHeaderDefault,
   localparam int LenW = $clog2(MAX_HEADER + 1),
   localparam int IdxW = (MAX_HEADER > 1) ? $clog2(MAX_HEADER) : 1
) (
   input  logic [MAX_HEADER-1:0]         flags,
   input  logic [fsws_pkg::PatternW-1:0] pattern,
   input  logic [LenW-1:0]               len,
   output logic                          hit
);

   logic [LenW-1:0]       base_full;
   logic [IdxW-1:0]       base;
   logic [MAX_HEADER-1:0] pattern_sh;
   logic [MAX_HEADER-1:0] mask;
   logic [MAX_HEADER-1:0] diff;

   // The oldest window flag sits at MAX_HEADER - len; len is at least one.
   assign base_full = LenW'(MAX_HEADER) - len;
   assign base      = base_full[IdxW-1:0];

   // Header bit k lines up with flag base + k.
   assign pattern_sh = pattern[MAX_HEADER-1:0] << base;
   assign mask       = {MAX_HEADER{1'b1}} << base;
   assign diff       = (flags ^ pattern_sh) & mask;

   // An exact match or an exact inversion counts as a header.
   assign hit = (diff == '0) || (diff == mask);

endmodule

>>> design/frame_sync_word_stripper.sv
// Channel   Ports                              Direction  Moves
// req       req_valid/req_ready/req_data_byte  in         one stream byte
// rsp       rsp_valid/rsp_ready/rsp_out_byte   out        one payload byte
// csr       csr_we/csr_index/csr_wdata         in         register write
//
// One byte is taken every cycle unless a stalled result holds the flow; each
// byte waits in the input register and is correlated and stripped on its way
// into the result register, through which its result reaches rsp; a stalled
// result holds the input register and then req_ready.
// Reset clears the counters, the found flag and both valid bits, and loads
// the registers with pattern zero and length eight.
module frame_sync_word_stripper #(
   parameter int MAX_HEADER = fsws_pkg::MaxHeaderDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fsws_pkg::ByteW-1:0]     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fsws_pkg::ByteW-1:0]     rsp_out_byte,
   input  logic                           csr_we,
   input  logic [fsws_pkg::CsrIndexW-1:0] csr_index,
   input  logic [fsws_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int LenW = $clog2(MAX_HEADER + 1);
   localparam int IdxW = (MAX_HEADER > 1) ? $clog2(MAX_HEADER) : 1;
   localparam int SumW = LenW + 1;

   // Configuration registers.
   logic [fsws_pkg::PatternW-1:0] pattern_ff;
   logic [fsws_pkg::HdrLenW-1:0]  length_ff;

   // Input register.
   logic                       in_valid_ff, in_valid_in;
   logic [fsws_pkg::ByteW-1:0] in_byte_ff;

   // Stream state.
   logic [fsws_pkg::ByteW-1:0] window_mem [MAX_HEADER];
   logic [IdxW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]            new_pos;
   logic [SumW-1:0]            rd_sum;
   logic [IdxW-1:0]            rd_addr;
   logic [fsws_pkg::ByteW-1:0] rd_data_ff;
   logic [fsws_pkg::ByteW-1:0] last_byte_ff;
   logic [MAX_HEADER-1:0]      flags_ff, flags_in;
   logic [LenW-1:0]            fill_ff, fill_in;
   logic [IdxW-1:0]            skip_ff, skip_in;
   logic                       found_ff, found_in;

   // Result register.
   logic                       out_valid_ff, out_valid_in;
   logic [fsws_pkg::ByteW-1:0] out_byte_ff, out_byte_in;

   logic            advance;
   logic [LenW-1:0] eff_len;
   logic [LenW-1:0] len_m1;
   logic            hit;
   logic            emit;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= fsws_pkg::PatternReset;
         length_ff  <= fsws_pkg::LengthReset;
      end else if (csr_we) begin
         case (csr_index)
            fsws_pkg::CsrHeaderPattern: pattern_ff <= csr_wdata;
            fsws_pkg::CsrHeaderLength:  length_ff  <= csr_wdata[fsws_pkg::HdrLenW-1:0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one; a length beyond the window acts as its depth.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LenW'(1);
      end else if (length_ff > fsws_pkg::HdrLenW'(MAX_HEADER)) begin
         eff_len = LenW'(MAX_HEADER);
      end else begin
         eff_len = length_ff[LenW-1:0];
      end
   end
   assign len_m1 = eff_len - LenW'(1);

   // The held byte moves on whenever the result register is free or drains.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_valid && req_ready ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Flag line shifted by one position, holding a nonzero flag for each byte.
   always_comb begin
      for (int i = 0; i < MAX_HEADER; i++) begin
         if (i == MAX_HEADER - 1) begin
            flags_in[i] = (in_byte_ff != '0);
         end else begin
            flags_in[i] = flags_ff[i+1];
         end
      end
   end

   fsws_corr #(
      .MAX_HEADER (MAX_HEADER)
   ) u_corr (
      .flags   (flags_in),
      .pattern (pattern_ff),
      .len     (eff_len),
      .hit     (hit)
   );

   // Fill, skip and header decisions for the byte that moves on.
   always_comb begin
      fill_in  = (fill_ff < LenW'(MAX_HEADER)) ? fill_ff + LenW'(1) : fill_ff;
      skip_in  = skip_ff;
      found_in = found_ff;
      emit     = 1'b0;
      if (fill_in >= eff_len) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - IdxW'(1);
         end else if (hit) begin
            found_in = 1'b1;
            skip_in  = len_m1[IdxW-1:0];
         end else begin
            emit = found_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         skip_ff  <= '0;
         found_ff <= 1'b0;
      end else if (advance) begin
         fill_ff  <= fill_in;
         skip_ff  <= skip_in;
         found_ff <= found_in;
      end
   end

   // Write pointer of the circular byte window.
   assign wr_ptr_in = (wr_ptr_ff == IdxW'(MAX_HEADER - 1)) ? '0 : wr_ptr_ff + IdxW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
      end else if (advance) begin
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // A byte taken now lands at new_pos; its oldest window byte is len - 1 slots back.
   assign new_pos = in_valid_ff ? wr_ptr_in : wr_ptr_ff;
   assign rd_sum  = SumW'(new_pos) + SumW'(LenW'(MAX_HEADER) - len_m1);
   assign rd_addr = (rd_sum >= SumW'(MAX_HEADER)) ? IdxW'(rd_sum - SumW'(MAX_HEADER))
                                                   : IdxW'(rd_sum);

   // Window memory: the held byte is written as it moves on, and the oldest
   // byte for the next window is read as that byte is taken. For lengths of
   // three and up the read slot was written by an earlier transfer.
   always_ff @(posedge clock) begin
      if (advance) begin
         window_mem[wr_ptr_ff] <= in_byte_ff;
      end
      if (req_valid && req_ready) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   // Only bytes already written are ever used, so these need no reset.
   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff     <= flags_in;
         last_byte_ff <= in_byte_ff;
      end
   end

   // Result register: the oldest window byte after the shift. Short windows
   // take it from the input register or from the byte before it.
   always_comb begin
      if (len_m1 == '0) begin
         out_byte_in = in_byte_ff;
      end else if (len_m1 == LenW'(1)) begin
         out_byte_in = last_byte_ff;
      end else begin
         out_byte_in = rd_data_ff;
      end
   end
   assign out_valid_in = advance ? emit : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_byte_ff <= out_byte_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

endmodule

>>> design/fsws_checker.sv
// Port-level checks for the sync word stripper.
module fsws_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fsws_pkg::ByteW-1:0] rsp_out_byte
);

   // A stalled result keeps its valid and its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result transfer changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A draining result side never holds back the input side.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("input stalled while the result side is ready");

   // The input side only stalls behind a waiting result.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind frame_sync_word_stripper fsws_checker u_fsws_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte)
);
